### hdl/crc32_crc32c_stream_core_assert.svh
// Assertion macros shared by the merge stage and the top level of the CRC stream core.
`ifndef CRC32_CRC32C_STREAM_CORE_ASSERT_SVH
`define CRC32_CRC32C_STREAM_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, suspended while rst is high.
`define CRCS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, suspended while rst is high.
`define CRCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/crcs_pkg.sv
// Shared constants, types and matrix functions for the CRC stream core.
package crcs_pkg;

  localparam int unsigned CRC_W          = 32;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned DATA_BYTES     = 8;
  localparam int unsigned DEF_WORD_BYTES = 8;
  localparam int unsigned MAX_WORD_BYTES = 16;
  localparam int unsigned CNT_W          = $clog2(MAX_WORD_BYTES + 1);
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 32;

  localparam logic [CRC_W-1:0] POLY_IEEE       = 32'hEDB88320;
  localparam logic [CRC_W-1:0] POLY_CASTAGNOLI = 32'h82F63B78;
  localparam logic [CRC_W-1:0] ALL_ONES        = 32'hFFFFFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_POLY_SELECT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED        = 1'd1;

  // Column j holds the image of unit vector j under the linear map.
  typedef logic [CRC_W-1:0][CRC_W-1:0] mat_t;

  // Per-item control carried from the lane stage to the merge stage.
  typedef struct packed {
    logic             start;
    logic             poly;
    logic [CNT_W-1:0] nbytes;
  } ctrl_t;

  // Matrix of folding the given number of zero bytes into a reflected CRC.
  function automatic mat_t pow_matrix(input logic [CRC_W-1:0] poly,
                                      input int unsigned nzero);
    mat_t             m;
    logic [CRC_W-1:0] v;
    for (int j = 0; j < int'(CRC_W); j++) begin
      v = CRC_W'(1) << j;
      for (int s = 0; s < int'(nzero * BYTE_W); s++) begin
        v = v[0] ? ((v >> 1) ^ poly) : (v >> 1);
      end
      m[j] = v;
    end
    return m;
  endfunction

  // Applies a matrix to a vector: an XOR of the selected columns.
  function automatic logic [CRC_W-1:0] mat_apply(input mat_t m,
                                                 input logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] acc;
    acc = '0;
    for (int j = 0; j < int'(CRC_W); j++) begin
      if (v[j]) begin
        acc = acc ^ m[j];
      end
    end
    return acc;
  endfunction

endpackage

### hdl/crcs_lane.sv
// One byte lane: registers the byte's contribution, advanced to the end of the item.
module crcs_lane #(
  parameter int unsigned WORD_BYTES = crcs_pkg::DEF_WORD_BYTES,
  parameter int unsigned LANE       = 0
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic [crcs_pkg::BYTE_W-1:0]   lane_byte,
  input  logic [crcs_pkg::CNT_W-1:0]    nbytes,
  input  logic                          poly_sel,
  output logic [crcs_pkg::CRC_W-1:0]    contrib
);

  crcs_pkg::mat_t                 mat_ieee [WORD_BYTES];
  crcs_pkg::mat_t                 mat_cast [WORD_BYTES];
  crcs_pkg::mat_t                 mat_sel;
  logic [crcs_pkg::CRC_W-1:0]     contrib_next;

  // Entry k advances the byte through k+1 byte steps.
  for (genvar k = 0; k < int'(WORD_BYTES); k++) begin : g_mat
    localparam crcs_pkg::mat_t M_IEEE =
      crcs_pkg::pow_matrix(crcs_pkg::POLY_IEEE, k + 1);
    localparam crcs_pkg::mat_t M_CAST =
      crcs_pkg::pow_matrix(crcs_pkg::POLY_CASTAGNOLI, k + 1);
    assign mat_ieee[k] = M_IEEE;
    assign mat_cast[k] = M_CAST;
  end

  // A lane at or beyond the byte count selects no matrix and adds nothing.
  always_comb begin
    mat_sel = '0;
    for (int k = 0; k < int'(WORD_BYTES); k++) begin
      if (int'(nbytes) == int'(LANE) + k + 1) begin
        mat_sel = poly_sel ? mat_cast[k] : mat_ieee[k];
      end
    end
    contrib_next = crcs_pkg::mat_apply(mat_sel, crcs_pkg::CRC_W'(lane_byte));
  end

  always_ff @(posedge clk) begin
    if (load) begin
      contrib <= contrib_next;
    end
  end

endmodule

### hdl/crcs_merge.sv
// Merge stage: combines lane contributions and updates the running CRC.
`include "crc32_crc32c_stream_core_assert.svh"

module crcs_merge #(
  parameter int unsigned WORD_BYTES = crcs_pkg::DEF_WORD_BYTES,
  parameter int unsigned LANES      = crcs_pkg::DEF_WORD_BYTES
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load,
  input  crcs_pkg::ctrl_t                       ctrl,
  input  logic [LANES-1:0][crcs_pkg::CRC_W-1:0] contribs,
  input  logic [crcs_pkg::CRC_W-1:0]            seed,
  output logic [crcs_pkg::CRC_W-1:0]            crc_state
);

  crcs_pkg::mat_t             mat_ieee [WORD_BYTES + 1];
  crcs_pkg::mat_t             mat_cast [WORD_BYTES + 1];
  crcs_pkg::mat_t             mat_sel;
  logic [crcs_pkg::CRC_W-1:0] fold;
  logic [crcs_pkg::CRC_W-1:0] base;
  logic [crcs_pkg::CRC_W-1:0] crc_state_next;

  // Entry k carries the starting value through k byte steps.
  for (genvar k = 0; k <= int'(WORD_BYTES); k++) begin : g_mat
    localparam crcs_pkg::mat_t M_IEEE =
      crcs_pkg::pow_matrix(crcs_pkg::POLY_IEEE, k);
    localparam crcs_pkg::mat_t M_CAST =
      crcs_pkg::pow_matrix(crcs_pkg::POLY_CASTAGNOLI, k);
    assign mat_ieee[k] = M_IEEE;
    assign mat_cast[k] = M_CAST;
  end

  always_comb begin
    fold = '0;
    for (int l = 0; l < int'(LANES); l++) begin
      fold = fold ^ contribs[l];
    end
    base    = ctrl.start ? seed : crc_state;
    mat_sel = '0;
    for (int k = 0; k <= int'(WORD_BYTES); k++) begin
      if (int'(ctrl.nbytes) == k) begin
        mat_sel = ctrl.poly ? mat_cast[k] : mat_ieee[k];
      end
    end
    crc_state_next = crcs_pkg::mat_apply(mat_sel, base) ^ fold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_state <= crcs_pkg::ALL_ONES;
    end else if (load) begin
      crc_state <= crc_state_next;
    end
  end

  `CRCS_ASSERT_NEXT(a_empty_item_keeps_crc, load && !ctrl.start && ctrl.nbytes == '0, crc_state == $past(crc_state), "empty item changed the running CRC")
  `CRCS_ASSERT_NEXT(a_empty_start_loads_seed, load && ctrl.start && ctrl.nbytes == '0, crc_state == $past(seed), "empty start item did not load the seed")

endmodule

### hdl/crc32_crc32c_stream_core.sv
// Top level of the streaming CRC-32 / CRC-32C engine.
//
// Input channel (item_valid / item_stall): each item carries up to eight
// message bytes in data_word, earliest byte in bits 7:0, a byte count and a
// start flag. The item is taken at a clock edge where item_valid is high and
// item_stall is low. A start item reloads the running CRC from the seed
// register before its bytes are folded in.
// Result channel (result_valid / result_stall): one result per item, the raw
// running CRC and the digest, its bitwise inverse. Results leave in order.
// An item passes through two registers, the lane stage and the merge stage's
// CRC register, which is also the result register. The block sustains one
// item per cycle while the receiver does not stall. That rate is set by the
// running-CRC loop in the merge stage, which advances the CRC over a whole
// item at once.
// When the receiver stalls, the result register holds its item and the lane
// stage can still take one more item; only with both full is item_stall set.
// Configuration writes go through cfg_wr_en, cfg_index and cfg_wdata and are
// expected only while the block is idle.
// Synchronous reset selects CRC-32, sets the seed and the running CRC to all
// ones, and empties both pipeline stages.
`include "crc32_crc32c_stream_core_assert.svh"

module crc32_crc32c_stream_core #(
  parameter int unsigned WORD_BYTES = crcs_pkg::DEF_WORD_BYTES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration port
  input  logic                                 cfg_wr_en,
  input  logic [crcs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [crcs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // item channel
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic [crcs_pkg::DATA_BYTES*crcs_pkg::BYTE_W-1:0] data_word,
  input  logic [3:0]                           byte_count,
  input  logic                                 start_req,
  // result channel
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [crcs_pkg::CRC_W-1:0]           running_crc_out,
  output logic [crcs_pkg::CRC_W-1:0]           digest
);

  // Byte positions beyond the data word fold as zero bytes, so they need no
  // lane of their own: they only count in the merge stage's advance.
  localparam int unsigned LANES =
    (WORD_BYTES < crcs_pkg::DATA_BYTES) ? WORD_BYTES : crcs_pkg::DATA_BYTES;

  logic                                  poly_select;
  logic [crcs_pkg::CRC_W-1:0]            seed;
  logic                                  s1_vld;
  crcs_pkg::ctrl_t                       s1_ctrl;
  logic [LANES-1:0][crcs_pkg::CRC_W-1:0] contribs;
  logic [crcs_pkg::CNT_W-1:0]            nbytes;
  logic                                  out_free;
  logic                                  s1_free;
  logic                                  s1_adv;
  logic                                  accept;

  // Configuration registers. Both indexes are decoded; nothing else exists.
  always_ff @(posedge clk) begin
    if (rst) begin
      poly_select <= 1'b0;
      seed        <= crcs_pkg::ALL_ONES;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        crcs_pkg::REG_POLY_SELECT: poly_select <= cfg_wdata[0];
        crcs_pkg::REG_SEED:        seed        <= cfg_wdata[crcs_pkg::CRC_W-1:0];
        default: ;
      endcase
    end
  end

  // A byte count above the word size saturates to the word size.
  assign nbytes = (crcs_pkg::CNT_W'(byte_count) > crcs_pkg::CNT_W'(WORD_BYTES)) ?
                  crcs_pkg::CNT_W'(WORD_BYTES) : crcs_pkg::CNT_W'(byte_count);

  // Flow control: each stage moves on whenever the stage after it has room.
  assign out_free   = !result_valid || !result_stall;
  assign s1_free    = !s1_vld || out_free;
  assign s1_adv     = s1_vld && out_free;
  assign accept     = item_valid && s1_free;
  assign item_stall = !s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_vld <= item_valid;
      end
      if (out_free) begin
        result_valid <= s1_vld;
      end
    end
  end

  // The polynomial choice travels with the item through the lane stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctrl.start  <= start_req;
      s1_ctrl.poly   <= poly_select;
      s1_ctrl.nbytes <= nbytes;
    end
  end

  // Lane stage: each lane advances its byte to the end of the item.
  for (genvar i = 0; i < int'(LANES); i++) begin : g_lane
    crcs_lane #(
      .WORD_BYTES (WORD_BYTES),
      .LANE       (i)
    ) u_lane (
      .clk       (clk),
      .load      (accept),
      .lane_byte (data_word[i*crcs_pkg::BYTE_W +: crcs_pkg::BYTE_W]),
      .nbytes    (nbytes),
      .poly_sel  (poly_select),
      .contrib   (contribs[i])
    );
  end

  // Merge stage: its CRC register is also the result register.
  crcs_merge #(
    .WORD_BYTES (WORD_BYTES),
    .LANES      (LANES)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_adv),
    .ctrl      (s1_ctrl),
    .contribs  (contribs),
    .seed      (seed),
    .crc_state (running_crc_out)
  );

  assign digest = ~running_crc_out;

  `CRCS_ASSERT_SAME(a_stall_only_when_full, item_stall, s1_vld && result_valid && result_stall, "item stalled with room in the pipeline")
  `CRCS_ASSERT_NEXT(a_accept_fills_lanes, item_valid && !item_stall, s1_vld, "accepted item did not reach the lane stage")
  `CRCS_ASSERT_NEXT(a_advance_gives_result, s1_adv, result_valid, "item left the lane stage without a result")

endmodule
